// ----- rtl/core/csmv_pkg.sv -----
// Shared types, constants and floating-point helper functions for the CSR row accumulator.
`timescale 1ns / 1ps

package csmv_pkg;

    localparam int X_DEPTH  = 4096;
    localparam int X_AW     = $clog2(X_DEPTH);
    localparam int MAX_ROWS = 65536;
    localparam int ROW_W    = $clog2(MAX_ROWS);

    localparam logic [63:0] FP_QNAN = 64'hFFF8_0000_0000_0000;

    typedef enum logic [1:0] {
        OP_LOAD  = 2'd0,
        OP_NZ    = 2'd1,
        OP_EMPTY = 2'd2,
        OP_START = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        ADD_IDLE,
        ADD_ALIGN,
        ADD_SUM,
        ADD_LZC,
        ADD_SHIFT,
        ADD_ROUND
    } t_add_st;

    // Item tag that rides along the product pipeline.
    typedef struct packed {
        logic v;
        t_op  op;
        logic last;
        logic ok;
    } t_tag;

    // Normalized mantissa waiting for the rounding increment.
    typedef struct packed {
        logic         sign;
        logic         inf;
        logic [10:0]  expf;
        logic [105:0] q;
        logic         sticky;
    } t_rnd;

    function automatic logic [6:0] lzc106(input logic [105:0] v);
        logic [6:0] n;
        logic       found;
        n     = 7'd106;
        found = 1'b0;
        for (int i = 105; i >= 0; i--) begin
            if (!found && v[i]) begin
                n     = 7'(105 - i);
                found = 1'b1;
            end
        end
        return n;
    endfunction

    // Value of p is p * 2^(k - 2150); place the leading one at bit 105, or lower for
    // a subnormal result, keeping shifted-out bits as sticky.
    function automatic t_rnd fp_shift(input logic sign, input logic [12:0] k,
                                      input logic [105:0] p, input logic [6:0] lz);
        logic signed [14:0] eres;
        logic signed [14:0] s;
        logic signed [14:0] neg;
        logic [6:0]         r;
        logic [105:0]       mask;
        t_rnd               o;
        eres     = $signed({2'b00, k}) - $signed({8'd0, lz}) - 15'sd1022;
        o.sign   = sign;
        o.inf    = 1'b0;
        o.expf   = 11'd0;
        o.q      = p;
        o.sticky = 1'b0;
        s        = $signed({8'd0, lz}) + eres - 15'sd1;
        neg      = -s;
        r        = (neg > 15'sd127) ? 7'd127 : neg[6:0];
        mask     = (106'd1 << r) - 106'd1;
        if (eres >= 15'sd2047) begin
            o.inf = 1'b1;
        end else if (eres >= 15'sd1) begin
            o.q    = p << lz;
            o.expf = eres[10:0];
        end else if (s >= 15'sd0) begin
            o.q = p << s[6:0];
        end else begin
            o.q      = p >> r;
            o.sticky = |(p & mask);
        end
        return o;
    endfunction

    // Round to nearest even; a carry out of the fraction bumps the exponent.
    function automatic logic [63:0] fp_round(input t_rnd x);
        logic        rnd;
        logic [62:0] mag;
        rnd = x.q[52] & ((|x.q[51:0]) | x.sticky | x.q[53]);
        mag = {x.expf, x.q[104:53]} + 63'(rnd);
        if (x.inf) begin
            return {x.sign, 11'h7FF, 52'd0};
        end
        return {x.sign, mag};
    endfunction

endpackage

// ----- rtl/core/csmv_if.sv -----
// Valid/ready channel interfaces for input items and row results.
`timescale 1ns / 1ps

interface csmv_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  opcode;
    logic [11:0] load_index;
    logic [31:0] column;
    logic [63:0] value_bits;
    logic        last_in_row;

    modport source (output valid, opcode, load_index, column, value_bits, last_in_row,
                    input ready);
    modport sink (input valid, opcode, load_index, column, value_bits, last_in_row,
                  output ready);
endinterface

interface csmv_out_if;
    logic        valid;
    logic        ready;
    logic [15:0] row_index;
    logic [63:0] row_sum_bits;
    logic        column_error;

    modport source (output valid, row_index, row_sum_bits, column_error, input ready);
    modport sink (input valid, row_index, row_sum_bits, column_error, output ready);
endinterface

// ----- rtl/core/csr_sparse_matvec_row_accumulate.sv -----
// Top level of the CSR sparse matrix-vector row accumulator in IEEE double precision.
`timescale 1ns / 1ps

// Items arrive on i_item and row results leave on o_res, each a valid/ready
// transfer. A load item writes one entry of the 4096-entry x store; the store
// has no reset, so a nonzero must only reference entries that were loaded. A
// nonzero reads x[column - column_base] from the store, goes through a six-stage
// multiplier and is added to the row sum by a sequential adder (align, add,
// count zeros, shift, round) that takes no new nonzero until its add is done;
// loads, empty rows and start items pass at one a cycle unless the tail is held.
// A row result (row index, sum, column error) is registered after the multiplier,
// and after the adder for an added closing nonzero; it waits in an output
// register while new items are taken. The user must write column_base through
// i_cfg_we / i_cfg_wdata only while idle; the block itself does not enforce it.

module csr_sparse_matvec_row_accumulate
    import csmv_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [31:0] i_cfg_wdata,
    csmv_in_if.sink     i_item,
    csmv_out_if.source  o_res
);

    logic [31:0] r_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base <= 32'd0;
        end else if (i_cfg_we) begin
            r_base <= i_cfg_wdata;
        end
    end

    // Pipeline advance: everything moves unless the tail refuses the product.
    logic        en, accept, take;
    t_tag        m_tag;
    logic [63:0] m_prod;
    t_op         in_op;

    assign en           = !m_tag.v || take;
    assign i_item.ready = en;
    assign accept       = i_item.valid && en;
    assign in_op        = t_op'(i_item.opcode);

    // Column check and store address.
    logic [32:0]     diff;
    logic            col_ok, load_ok;
    logic [X_AW-1:0] rd_addr;

    assign diff    = {1'b0, i_item.column} - {1'b0, r_base};
    assign col_ok  = !diff[32] && (diff[31:0] < 32'(X_DEPTH));
    assign load_ok = 32'(i_item.load_index) < 32'(X_DEPTH);
    assign rd_addr = diff[X_AW-1:0];

    // x store: one write and one registered read per cycle; the read holds when the pipeline stalls.
    logic [63:0] x_mem [X_DEPTH];
    logic [63:0] r_xrd;

    always_ff @(posedge i_clk) begin
        if (accept && in_op == OP_LOAD && load_ok) begin
            x_mem[X_AW'(i_item.load_index)] <= i_item.value_bits;
        end
        if (en) begin
            r_xrd <= x_mem[rd_addr];
        end
    end

    // Stage A: hold the item while its x entry is read. Drop loads here.
    t_tag        r_a_tag, a_tag_in;
    logic [63:0] r_a_val;

    always_comb begin
        a_tag_in.v    = accept && (in_op != OP_LOAD);
        a_tag_in.op   = in_op;
        a_tag_in.last = i_item.last_in_row;
        a_tag_in.ok   = col_ok;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_tag <= '0;
        end else if (en) begin
            r_a_tag <= a_tag_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_a_val <= i_item.value_bits;
        end
    end

    csmv_fmul u_fmul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_tag   (r_a_tag),
        .i_a     (r_a_val),
        .i_b     (r_xrd),
        .o_tag   (m_tag),
        .o_prod  (m_prod)
    );

    // Row accumulator: the adder owns the sum until it finishes.
    logic             add_start, add_busy, add_done;
    logic [63:0]      add_sum;
    logic [63:0]      r_acc, n_acc, e_sum;
    logic             r_err, n_err, e_err;
    logic [ROW_W-1:0] r_row, n_row;
    logic             r_busy, n_busy, r_pend, n_pend, r_add_last, n_add_last;
    logic             emit, out_free;

    csmv_fadd u_fadd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (add_start),
        .i_a     (r_acc),
        .i_b     (m_prod),
        .o_busy  (add_busy),
        .o_done  (add_done),
        .o_sum   (add_sum)
    );

    assign out_free = !o_res.valid || o_res.ready;

    always_comb begin
        n_acc      = r_acc;
        n_err      = r_err;
        n_row      = r_row;
        n_busy     = r_busy;
        n_pend     = r_pend;
        n_add_last = r_add_last;
        emit       = 1'b0;
        add_start  = 1'b0;
        take       = 1'b0;
        if (r_busy) begin
            if (add_done) begin
                n_busy = 1'b0;
                n_acc  = add_sum;
                if (r_add_last) begin
                    if (out_free) begin
                        emit = 1'b1;
                    end else begin
                        n_pend = 1'b1;
                    end
                end
            end
        end else if (r_pend) begin
            // Closed row waits for the output register to free up.
            if (out_free) begin
                emit   = 1'b1;
                n_pend = 1'b0;
            end
        end else if (m_tag.v && !add_busy) begin
            case (m_tag.op)
                OP_NZ: begin
                    if (m_tag.ok) begin
                        take       = 1'b1;
                        add_start  = 1'b1;
                        n_busy     = 1'b1;
                        n_add_last = m_tag.last;
                    end else if (!m_tag.last) begin
                        take  = 1'b1;
                        n_err = 1'b1;
                    end else if (out_free) begin
                        take  = 1'b1;
                        n_err = 1'b1;
                        emit  = 1'b1;
                    end
                end
                OP_EMPTY: begin
                    if (out_free) begin
                        take = 1'b1;
                        emit = 1'b1;
                    end
                end
                OP_START: begin
                    // Discard any partial row and restart the row count.
                    take  = 1'b1;
                    n_row = '0;
                    n_acc = 64'd0;
                    n_err = 1'b0;
                end
                OP_LOAD: begin
                    take = 1'b1;
                end
            endcase
        end
        e_sum = n_acc;
        e_err = n_err;
        if (emit) begin
            n_acc = 64'd0;
            n_err = 1'b0;
            n_row = (r_row == ROW_W'(MAX_ROWS - 1)) ? '0 : r_row + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc      <= 64'd0;
            r_err      <= 1'b0;
            r_row      <= '0;
            r_busy     <= 1'b0;
            r_pend     <= 1'b0;
            r_add_last <= 1'b0;
        end else begin
            r_acc      <= n_acc;
            r_err      <= n_err;
            r_row      <= n_row;
            r_busy     <= n_busy;
            r_pend     <= n_pend;
            r_add_last <= n_add_last;
        end
    end

    // Output register: hold a result until its transfer completes.
    logic        r_out_v;
    logic [15:0] r_out_row;
    logic [63:0] r_out_sum;
    logic        r_out_err;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v <= 1'b0;
        end else if (emit) begin
            r_out_v <= 1'b1;
        end else if (o_res.ready) begin
            r_out_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_row <= 16'(r_row);
            r_out_sum <= e_sum;
            r_out_err <= e_err;
        end
    end

    assign o_res.valid        = r_out_v;
    assign o_res.row_index    = r_out_row;
    assign o_res.row_sum_bits = r_out_sum;
    assign o_res.column_error = r_out_err;

endmodule

// ----- rtl/core/csmv_fmul.sv -----
// Six-stage pipelined IEEE double multiplier with a tag carried alongside.
`timescale 1ns / 1ps

module csmv_fmul
    import csmv_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  t_tag        i_tag,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output t_tag        o_tag,
    output logic [63:0] o_prod
);

    typedef struct packed {
        logic        sign;
        logic [12:0] k;
        logic        spec;
        logic [63:0] spec_bits;
    } t_side;

    logic [10:0] ea, eb, eaf, ebf;
    logic [51:0] fa, fb;
    logic [52:0] ma, mb;
    logic        a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;
    logic [51:0] pp_hh;
    logic [52:0] pp_hl, pp_lh;
    logic [53:0] pp_ll;
    t_side       sb_in;

    assign ea     = i_a[62:52];
    assign eb     = i_b[62:52];
    assign fa     = i_a[51:0];
    assign fb     = i_b[51:0];
    assign eaf    = (ea == 11'd0) ? 11'd1 : ea;
    assign ebf    = (eb == 11'd0) ? 11'd1 : eb;
    assign ma     = {ea != 11'd0, fa};
    assign mb     = {eb != 11'd0, fb};
    assign a_nan  = (ea == 11'h7FF) && (fa != 52'd0);
    assign b_nan  = (eb == 11'h7FF) && (fb != 52'd0);
    assign a_inf  = (ea == 11'h7FF) && (fa == 52'd0);
    assign b_inf  = (eb == 11'h7FF) && (fb == 52'd0);
    assign a_zero = (ea == 11'd0) && (fa == 52'd0);
    assign b_zero = (eb == 11'd0) && (fb == 52'd0);

    assign pp_hh = ma[52:27] * mb[52:27];
    assign pp_hl = ma[52:27] * mb[26:0];
    assign pp_lh = ma[26:0] * mb[52:27];
    assign pp_ll = ma[26:0] * mb[26:0];

    always_comb begin
        sb_in.sign      = i_a[63] ^ i_b[63];
        sb_in.k         = {2'b00, eaf} + {2'b00, ebf};
        sb_in.spec      = 1'b1;
        sb_in.spec_bits = 64'd0;
        if (a_nan) begin
            sb_in.spec_bits = i_a | 64'h0008_0000_0000_0000;
        end else if (b_nan) begin
            sb_in.spec_bits = i_b | 64'h0008_0000_0000_0000;
        end else if ((a_inf && b_zero) || (a_zero && b_inf)) begin
            sb_in.spec_bits = FP_QNAN;
        end else if (a_inf || b_inf) begin
            sb_in.spec_bits = {sb_in.sign, 11'h7FF, 52'd0};
        end else if (a_zero || b_zero) begin
            sb_in.spec_bits = {sb_in.sign, 63'd0};
        end else begin
            sb_in.spec = 1'b0;
        end
    end

    t_tag         r1_tag, r2_tag, r3_tag, r4_tag, r5_tag, r6_tag;
    t_side        r1_sb, r2_sb, r3_sb, r4_sb, r5_sb;
    logic [51:0]  r1_hh, r2_hh;
    logic [52:0]  r1_hl, r1_lh;
    logic [53:0]  r1_ll, r2_ll, r2_mid;
    logic [105:0] r3_p, r4_p;
    logic [6:0]   r4_lz;
    t_rnd         r5_rnd;
    logic [63:0]  r6_prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_tag <= '0;
            r2_tag <= '0;
            r3_tag <= '0;
            r4_tag <= '0;
            r5_tag <= '0;
            r6_tag <= '0;
        end else if (i_en) begin
            r1_tag <= i_tag;
            r2_tag <= r1_tag;
            r3_tag <= r2_tag;
            r4_tag <= r3_tag;
            r5_tag <= r4_tag;
            r6_tag <= r5_tag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_sb   <= sb_in;
            r1_hh   <= pp_hh;
            r1_hl   <= pp_hl;
            r1_lh   <= pp_lh;
            r1_ll   <= pp_ll;
            r2_sb   <= r1_sb;
            r2_hh   <= r1_hh;
            r2_ll   <= r1_ll;
            r2_mid  <= {1'b0, r1_hl} + {1'b0, r1_lh};
            r3_sb   <= r2_sb;
            r3_p    <= ({54'd0, r2_hh} << 54) + ({52'd0, r2_mid} << 27) + {52'd0, r2_ll};
            r4_sb   <= r3_sb;
            r4_p    <= r3_p;
            r4_lz   <= lzc106(r3_p);
            r5_sb   <= r4_sb;
            r5_rnd  <= fp_shift(r4_sb.sign, r4_sb.k, r4_p, r4_lz);
            r6_prod <= r5_sb.spec ? r5_sb.spec_bits : fp_round(r5_rnd);
        end
    end

    assign o_tag  = r6_tag;
    assign o_prod = r6_prod;

endmodule

// ----- rtl/core/csmv_fadd.sv -----
// Multi-cycle IEEE double adder: align, add, count zeros, shift, round.
`timescale 1ns / 1ps

module csmv_fadd
    import csmv_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic [63:0] i_a,
    input  logic [63:0] i_b,
    output logic        o_busy,
    output logic        o_done,
    output logic [63:0] o_sum
);

    t_add_st r_st, n_st;

    logic [63:0]  r_a, r_b;
    logic [105:0] r_big, r_small, r_f;
    logic         r_sub, r_sign, r_zsign, r_spec, r_fz;
    logic [12:0]  r_k;
    logic [63:0]  r_spec_bits;
    logic [6:0]   r_lz;
    t_rnd         r_rnd;

    // Alignment of the smaller operand.
    logic [10:0]  ea, eb, eaf, ebf, e_big, e_sml, d;
    logic [51:0]  fa, fb;
    logic [52:0]  ma, mb, m_big, m_sml;
    logic         a_ge, a_nan, b_nan, a_inf, b_inf;
    logic [6:0]   sh;
    logic [105:0] sml_f, sml_sh, mask;
    logic         spec;
    logic [63:0]  spec_bits;

    always_comb begin
        ea    = r_a[62:52];
        eb    = r_b[62:52];
        fa    = r_a[51:0];
        fb    = r_b[51:0];
        eaf   = (ea == 11'd0) ? 11'd1 : ea;
        ebf   = (eb == 11'd0) ? 11'd1 : eb;
        ma    = {ea != 11'd0, fa};
        mb    = {eb != 11'd0, fb};
        a_nan = (ea == 11'h7FF) && (fa != 52'd0);
        b_nan = (eb == 11'h7FF) && (fb != 52'd0);
        a_inf = (ea == 11'h7FF) && (fa == 52'd0);
        b_inf = (eb == 11'h7FF) && (fb == 52'd0);
        a_ge  = r_a[62:0] >= r_b[62:0];
        e_big = a_ge ? eaf : ebf;
        e_sml = a_ge ? ebf : eaf;
        m_big = a_ge ? ma : mb;
        m_sml = a_ge ? mb : ma;
        d     = e_big - e_sml;
        sh    = (d > 11'd127) ? 7'd127 : d[6:0];
        sml_f = {1'b0, m_sml, 52'd0};
        mask  = (106'd1 << sh) - 106'd1;
        sml_sh = sml_f >> sh;
        sml_sh[0] = sml_sh[0] | (|(sml_f & mask));
        spec      = 1'b1;
        spec_bits = 64'd0;
        if (a_nan) begin
            spec_bits = r_a | 64'h0008_0000_0000_0000;
        end else if (b_nan) begin
            spec_bits = r_b | 64'h0008_0000_0000_0000;
        end else if (a_inf && b_inf && (r_a[63] != r_b[63])) begin
            spec_bits = FP_QNAN;
        end else if (a_inf) begin
            spec_bits = r_a;
        end else if (b_inf) begin
            spec_bits = r_b;
        end else begin
            spec = 1'b0;
        end
    end

    always_comb begin
        n_st = r_st;
        unique case (r_st)
            ADD_IDLE:  if (i_start) n_st = ADD_ALIGN;
            ADD_ALIGN: n_st = ADD_SUM;
            ADD_SUM:   n_st = ADD_LZC;
            ADD_LZC:   n_st = ADD_SHIFT;
            ADD_SHIFT: n_st = ADD_ROUND;
            ADD_ROUND: n_st = ADD_IDLE;
            default:   n_st = ADD_IDLE;
        endcase
    end

    always_comb begin
        o_busy = 1'b1;
        o_done = 1'b0;
        unique case (r_st)
            ADD_IDLE:  o_busy = 1'b0;
            ADD_ROUND: o_done = 1'b1;
            default:   o_busy = 1'b1;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ADD_IDLE;
        end else begin
            r_st <= n_st;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_st == ADD_IDLE && i_start) begin
            r_a <= i_a;
            r_b <= i_b;
        end
        if (r_st == ADD_ALIGN) begin
            r_big       <= {1'b0, m_big, 52'd0};
            r_small     <= sml_sh;
            r_sub       <= r_a[63] ^ r_b[63];
            r_sign      <= a_ge ? r_a[63] : r_b[63];
            r_zsign     <= r_a[63] & r_b[63];
            r_k         <= {2'b00, e_big} + 13'd1023;
            r_spec      <= spec;
            r_spec_bits <= spec_bits;
        end
        if (r_st == ADD_SUM) begin
            r_f <= r_sub ? (r_big - r_small) : (r_big + r_small);
        end
        if (r_st == ADD_LZC) begin
            r_lz <= lzc106(r_f);
            r_fz <= (r_f == 106'd0);
        end
        if (r_st == ADD_SHIFT) begin
            r_rnd <= fp_shift(r_sign, r_k, r_f, r_lz);
        end
    end

    always_comb begin
        if (r_spec) begin
            o_sum = r_spec_bits;
        end else if (r_fz) begin
            o_sum = {r_zsign, 63'd0};
        end else begin
            o_sum = fp_round(r_rnd);
        end
    end

endmodule

// ----- bench/csr_sparse_matvec_row_accumulate_tb.sv -----
// Self-checking testbench for the CSR sparse matrix-vector row accumulator.
`timescale 1ns / 1ps

module csr_sparse_matvec_row_accumulate_tb;
    import csmv_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 20;

    typedef struct {
        logic [15:0] row;
        logic [63:0] sum;
        logic        err;
    } t_row_result;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_cfg_we = 1'b0;
    logic [31:0] i_cfg_wdata = '0;

    // Testbench-side copies of the channel signals, known from time zero.
    logic        item_valid = 1'b0;
    logic [1:0]  item_op = OP_LOAD;
    logic [11:0] item_idx = '0;
    logic [31:0] item_col = '0;
    logic [63:0] item_val = '0;
    logic        item_last = 1'b0;
    logic        res_ready = 1'b0;

    csmv_in_if  item_if ();
    csmv_out_if res_if ();

    assign item_if.valid       = item_valid;
    assign item_if.opcode      = item_op;
    assign item_if.load_index  = item_idx;
    assign item_if.column      = item_col;
    assign item_if.value_bits  = item_val;
    assign item_if.last_in_row = item_last;
    assign res_if.ready        = res_ready;

    csr_sparse_matvec_row_accumulate dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_item      (item_if),
        .o_res       (res_if)
    );

    always #10 i_clk = ~i_clk;

    // Predictor state: x store, row sum, row counter, error flag, column base.
    logic [63:0]  x_mem [X_DEPTH];
    bit           x_loaded [X_DEPTH];
    int unsigned  loaded_list [$];
    real          row_acc;
    logic [15:0]  row_cnt;
    logic         row_err;
    logic [31:0]  col_base;

    t_row_result  pending_rows [$];
    int           error_count;
    bit           idle_on;
    int           stall_left;
    int           quiet_cycles;

    // Close the open row into the store of pending row results.
    task automatic close_row();
        t_row_result r;
        r.row = row_cnt;
        r.sum = $realtobits(row_acc);
        r.err = row_err;
        pending_rows.push_back(r);
        row_acc = 0.0;
        row_err = 1'b0;
        row_cnt = row_cnt + 16'd1;
    endtask

    task automatic accumulate(input t_op op, input logic [11:0] idx, input logic [31:0] col,
                              input logic [63:0] val, input logic last);
        logic [31:0] off;
        case (op)
            OP_LOAD: begin
                x_mem[idx] = val;
                if (!x_loaded[idx]) loaded_list.push_back(idx);
                x_loaded[idx] = 1'b1;
            end
            OP_NZ: begin
                off = col - col_base;
                if (col >= col_base && off < X_DEPTH) begin
                    // Round the product, then round the add; no fused operation.
                    row_acc = row_acc + $bitstoreal(val) * $bitstoreal(x_mem[off]);
                end else begin
                    row_err = 1'b1;
                end
                if (last) close_row();
            end
            OP_EMPTY: close_row();
            default: begin
                row_cnt = '0;
                row_acc = 0.0;
                row_err = 1'b0;
            end
        endcase
    endtask

    // Drive one item, hold it until the transfer, then predict its effect.
    task automatic send_item(input t_op op, input logic [11:0] idx, input logic [31:0] col,
                             input logic [63:0] val, input logic last);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge i_clk);
        end
        item_valid <= 1'b1;
        item_op    <= op;
        item_idx   <= idx;
        item_col   <= col;
        item_val   <= val;
        item_last  <= last;
        @(posedge i_clk);
        while (!item_if.ready) @(posedge i_clk);
        accumulate(op, idx, col, val, last);
    endtask

    task automatic release_bus();
        item_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // Wait for every pending row, let the pipeline settle, then write column_base.
    task automatic write_base(input logic [31:0] b);
        release_bus();
        while (pending_rows.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= b;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        col_base = b;
        @(posedge i_clk);
    endtask

    function automatic logic [63:0] rand_double();
        logic [63:0] v;
        v = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0, 1:    ; // raw bits: NaN, inf, subnormals and all
            2:       v = {v[63], 11'd0, v[51:0]};
            3:       v = {v[63], 63'd0};
            default: v = {v[63], 11'($urandom_range(1013, 1033)), v[51:0]};
        endcase
        return v;
    endfunction

    function automatic bit col_readable(input logic [31:0] col);
        logic [31:0] off;
        off = col - col_base;
        return !(col >= col_base && off < X_DEPTH) || x_loaded[off];
    endfunction

    // Column outside the local window, or inside it only where the entry is loaded.
    function automatic logic [31:0] stray_column();
        logic [31:0] c;
        c = $urandom;
        if ($urandom_range(0, 1) == 0) begin
            if (col_base != 0) c = $urandom_range(0, col_base - 1);
            else c = 32'd4096 + 32'($urandom_range(0, 65535));
        end
        while (!col_readable(c)) c = $urandom;
        return c;
    endfunction

    function automatic logic [31:0] local_column();
        logic [31:0] c;
        c = col_base + 32'(loaded_list[$urandom_range(0, loaded_list.size() - 1)]);
        if (!col_readable(c)) c = stray_column();
        return c;
    endfunction

    // Compare each result transfer with the oldest pending row; stall in bursts.
    always @(posedge i_clk) begin
        t_row_result exp_r;
        bit          sum_ok;
        if (res_if.valid && res_ready) begin
            if (pending_rows.size() == 0) begin
                $display("%0t unexpected row result: row %h sum %h err %b", $time,
                         res_if.row_index, res_if.row_sum_bits, res_if.column_error);
                error_count++;
            end else begin
                exp_r = pending_rows.pop_front();
                // Any NaN is accepted where NaN is predicted; payloads are not defined.
                if (exp_r.sum[62:52] == 11'h7FF && exp_r.sum[51:0] != 0)
                    sum_ok = res_if.row_sum_bits[62:52] == 11'h7FF &&
                             res_if.row_sum_bits[51:0] != 0;
                else
                    sum_ok = res_if.row_sum_bits === exp_r.sum;
                if (res_if.row_index !== exp_r.row) begin
                    $display("%0t row_index mismatch: expected %h actual %h", $time,
                             exp_r.row, res_if.row_index);
                    error_count++;
                end
                if (!sum_ok) begin
                    $display("%0t row_sum_bits mismatch: expected %h actual %h", $time,
                             exp_r.sum, res_if.row_sum_bits);
                    error_count++;
                end
                if (res_if.column_error !== exp_r.err) begin
                    $display("%0t column_error mismatch: expected %b actual %b", $time,
                             exp_r.err, res_if.column_error);
                    error_count++;
                end
            end
        end
        if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            res_ready  <= 1'b0;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            stall_left <= $urandom_range(0, 9);
            res_ready  <= 1'b0;
        end else begin
            res_ready <= 1'b1;
        end
    end

    // Count cycles with no transfer on either channel; end the run when stuck.
    always @(posedge i_clk) begin
        if ((item_if.valid && item_if.ready) || (res_if.valid && res_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Directed: store ends, overflow, NaN, subnormal, stray columns, empty and start.
    task automatic test_directed();
        send_item(OP_LOAD, 12'd0, '0, 64'h3FF8_0000_0000_0000, 1'b0);
        send_item(OP_LOAD, 12'd4095, '1, 64'hC000_0000_0000_0000, 1'b1);
        send_item(OP_LOAD, 12'd7, '0, 64'h7FEF_FFFF_FFFF_FFFF, 1'b0);
        send_item(OP_LOAD, 12'd8, '0, 64'h7FF0_0000_0000_0000, 1'b0);
        send_item(OP_LOAD, 12'd9, '0, 64'h0000_0000_0000_0001, 1'b0);
        send_item(OP_LOAD, 12'd10, '0, 64'h8000_0000_0000_0000, 1'b0);
        send_item(OP_EMPTY, '1, '1, '1, 1'b1);
        send_item(OP_NZ, 12'hABC, 32'd0, 64'h4000_0000_0000_0000, 1'b0);
        send_item(OP_NZ, '0, 32'd4095, 64'h4008_0000_0000_0000, 1'b1);
        send_item(OP_NZ, '0, 32'd7, 64'h7FEF_FFFF_FFFF_FFFF, 1'b0);
        send_item(OP_NZ, '0, 32'd7, 64'h7FEF_FFFF_FFFF_FFFF, 1'b1);
        send_item(OP_NZ, '0, 32'd8, 64'h0000_0000_0000_0000, 1'b1);
        send_item(OP_NZ, '0, 32'd9, 64'h3FE0_0000_0000_0000, 1'b0);
        send_item(OP_NZ, '0, 32'd9, 64'h4010_0000_0000_0000, 1'b1);
        send_item(OP_NZ, '0, 32'd10, 64'h8000_0000_0000_0000, 1'b1);
        send_item(OP_NZ, '0, 32'd4096, 64'h3FF0_0000_0000_0000, 1'b1);
        send_item(OP_NZ, '0, 32'hFFFF_FFFF, 64'hBFF0_0000_0000_0000, 1'b1);
        send_item(OP_NZ, '0, 32'd0, 64'h3FF0_0000_0000_0000, 1'b0);
        send_item(OP_EMPTY, '0, '0, '0, 1'b0);
        send_item(OP_NZ, '0, 32'd0, 64'h3FF0_0000_0000_0000, 1'b0);
        send_item(OP_START, '1, '1, '1, 1'b1);
        send_item(OP_EMPTY, '0, '0, '0, 1'b0);
    endtask

    // Random: mostly well-formed rows over loaded entries, with loads, empties,
    // restarts and stray columns mixed in.
    task automatic test_random_rows(input int count);
        int sent;
        int pick;
        int row_len;
        sent = 0;
        repeat (8) send_item(OP_LOAD, 12'($urandom), $urandom, rand_double(), 1'($urandom));
        while (sent < count) begin
            pick = $urandom_range(0, 99);
            if (pick < 12) begin
                send_item(OP_LOAD, 12'($urandom), $urandom, rand_double(), 1'($urandom));
                sent++;
            end else if (pick < 20) begin
                send_item(OP_EMPTY, 12'($urandom), $urandom, {$urandom, $urandom},
                          1'($urandom));
                sent++;
            end else if (pick < 24) begin
                send_item(OP_START, 12'($urandom), $urandom, {$urandom, $urandom},
                          1'($urandom));
                sent++;
            end else begin
                row_len = $urandom_range(1, 6);
                for (int k = 0; k < row_len; k++) begin
                    send_item(OP_NZ, 12'($urandom),
                              ($urandom_range(0, 9) == 0) ? stray_column() : local_column(),
                              rand_double(), k == row_len - 1);
                    sent++;
                end
            end
        end
    endtask

    task automatic test_base_zero();
        test_random_rows(280);
    endtask

    task automatic test_base_mid();
        write_base(32'd1000);
        send_item(OP_NZ, '0, 32'd999, 64'h3FF0_0000_0000_0000, 1'b1);
        send_item(OP_NZ, '0, 32'd1000, 64'h3FF0_0000_0000_0000, 1'b1);
        test_random_rows(180);
    endtask

    task automatic test_base_top();
        write_base(32'hFFFF_FFFF);
        test_random_rows(50);
        write_base(32'hFFFF_F000);
        send_item(OP_NZ, '0, 32'hFFFF_FFFF, 64'h3FF0_0000_0000_0000, 1'b1);
        test_random_rows(100);
    endtask

    // Last part: random base, no idling on either side.
    task automatic test_base_random_no_idle();
        write_base($urandom);
        idle_on = 1'b0;
        test_random_rows(200);
    endtask

    initial begin
        foreach (x_loaded[i]) x_loaded[i] = 1'b0;
        row_acc      = 0.0;
        row_cnt      = '0;
        row_err      = 1'b0;
        col_base     = '0;
        error_count  = 0;
        idle_on      = 1'b1;
        stall_left   = 0;
        quiet_cycles = 0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        // Write the reset value first so the register is exercised at its low end.
        write_base(32'd0);
        test_directed();
        test_base_zero();
        test_base_mid();
        test_base_top();
        test_base_random_no_idle();
        release_bus();
        while (pending_rows.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule

// ----- csr_sparse_matvec_row_accumulate.f -----
rtl/core/csmv_pkg.sv
rtl/core/csmv_if.sv
rtl/core/csmv_fmul.sv
rtl/core/csmv_fadd.sv
rtl/core/csr_sparse_matvec_row_accumulate.sv
bench/csr_sparse_matvec_row_accumulate_tb.sv
